### rtl/htp_pkg.sv
package htp_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [8:0][31:0] mat_t;

  typedef enum logic [2:0] {
    CFG_KINV_00_01 = 3'd0,
    CFG_KINV_02_10 = 3'd1,
    CFG_KINV_11_12 = 3'd2,
    CFG_KINV_20_21 = 3'd3,
    CFG_KINV_22    = 3'd4,
    CFG_TAG_SIDE   = 3'd5
  } cfg_idx_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int FRONT_STG  = 9;

  localparam logic [63:0] KINV_DIAG_RST = 64'h1000_0000_0000_0000;
  localparam logic [31:0] KINV_22_RST   = 32'h1000_0000;
  localparam logic [11:0] TAG_SIDE_RST  = 12'd173;
  localparam logic [9:0]  MM_PER_M      = 10'd1000;
  localparam logic [31:0] WORD_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_lane_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
    logic [31:0] lo;
  } rdiv_t;

  typedef struct packed {
    logic [42:0] rem;
    logic [31:0] q;
    logic [31:0] lo;
  } tdiv_t;

  // one bit of the integer square root, from the next two bits of the radicand
  function automatic sq_lane_t sqrt_step(sq_lane_t s);
    sq_lane_t    n;
    logic [35:0] rem2;
    logic [35:0] trial;
    rem2  = {s.rem[33:0], s.x[63:62]};
    trial = {2'b00, s.root, 2'b01};
    n.x   = {s.x[61:0], 2'b00};
    if (rem2 >= trial) begin
      n.rem  = rem2 - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = rem2;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic rdiv_t rdiv_step(rdiv_t s, logic [31:0] d);
    rdiv_t       n;
    logic [32:0] r2;
    r2   = {s.rem, s.lo[31]};
    n.lo = {s.lo[30:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      n.rem = 32'(r2 - {1'b0, d});
      n.q   = {s.q[30:0], 1'b1};
    end else begin
      n.rem = r2[31:0];
      n.q   = {s.q[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic tdiv_t tdiv_step(tdiv_t s, logic [42:0] d);
    tdiv_t       n;
    logic [43:0] r2;
    r2   = {s.rem, s.lo[31]};
    n.lo = {s.lo[30:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      n.rem = 43'(r2 - {1'b0, d});
      n.q   = {s.q[30:0], 1'b1};
    end else begin
      n.rem = r2[42:0];
      n.q   = {s.q[30:0], 1'b0};
    end
    return n;
  endfunction

endpackage

### rtl/homography_to_pose.sv
// homography to pose: takes a 3x3 planar homography (signed Q16.16, row major)
// and returns the camera rotation (signed Q2.30) and translation in meters
// (signed Q8.24, saturated), using the inverse intrinsics and tag side held in
// the cfg registers.
// a transaction is taken at each rising edge with start high; busy is always
// low, so one homography can enter every cycle. a transaction with
// in_tag_detected low is taken but gives no result.
// each result shows on the out_ ports for exactly one cycle with out_valid
// high, once its transaction has passed the front stages, the 32-stage square
// root and the 32-stage dividers that follow it.
// the receiver cannot stall, so nothing inside ever holds.
// cfg registers are written through cfg_we / cfg_idx / cfg_wdata and should
// only change while no transaction is in flight.
// reset (rst_n low at a clock edge) empties the pipeline and loads the
// identity intrinsics and a 173 mm tag side.
module homography_to_pose
  import htp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_tag_detected,
  input  logic [31:0] in_h_00,
  input  logic [31:0] in_h_01,
  input  logic [31:0] in_h_02,
  input  logic [31:0] in_h_10,
  input  logic [31:0] in_h_11,
  input  logic [31:0] in_h_12,
  input  logic [31:0] in_h_20,
  input  logic [31:0] in_h_21,
  input  logic [31:0] in_h_22,
  output logic        out_valid,
  output logic [31:0] out_r_00,
  output logic [31:0] out_r_01,
  output logic [31:0] out_r_02,
  output logic [31:0] out_r_10,
  output logic [31:0] out_r_11,
  output logic [31:0] out_r_12,
  output logic [31:0] out_r_20,
  output logic [31:0] out_r_21,
  output logic [31:0] out_r_22,
  output logic [31:0] out_t_x,
  output logic [31:0] out_t_y,
  output logic [31:0] out_t_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  typedef struct packed {
    mat_t     b;
    sq_lane_t la;
    sq_lane_t lb;
  } sq_t;

  typedef struct packed {
    mat_t            b;
    logic [31:0]     na;
    logic [31:0]     nb;
    logic [2:0][42:0] num;
    logic [42:0]     den;
  } mt_t;

  typedef struct packed {
    logic [5:0]       rsgn;
    logic [2:0]       tsgn;
    logic [2:0]       tsat;
    logic             na_z;
    logic             nb_z;
    logic             den_z;
    logic [31:0]      na;
    logic [31:0]      nb;
    logic [42:0]      den;
    logic [5:0][95:0] rot;
    logic [2:0][106:0] tr;
  } dv_t;

  // ---------------- configuration ----------------
  logic [63:0] kinv_00_01_r, kinv_02_10_r, kinv_11_12_r, kinv_20_21_r;
  logic [31:0] kinv_22_r;
  logic [11:0] tag_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinv_00_01_r <= KINV_DIAG_RST;
      kinv_02_10_r <= '0;
      kinv_11_12_r <= KINV_DIAG_RST;
      kinv_20_21_r <= '0;
      kinv_22_r    <= KINV_22_RST;
      tag_side_r   <= TAG_SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KINV_00_01: kinv_00_01_r <= cfg_wdata;
        CFG_KINV_02_10: kinv_02_10_r <= cfg_wdata;
        CFG_KINV_11_12: kinv_11_12_r <= cfg_wdata;
        CFG_KINV_20_21: kinv_20_21_r <= cfg_wdata;
        CFG_KINV_22:    kinv_22_r    <= cfg_wdata[31:0];
        CFG_TAG_SIDE:   tag_side_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  word_t kin [3][3];
  word_t hin [3][3];

  always_comb begin
    kin[0][0] = kinv_00_01_r[63:32];
    kin[0][1] = kinv_00_01_r[31:0];
    kin[0][2] = kinv_02_10_r[63:32];
    kin[1][0] = kinv_02_10_r[31:0];
    kin[1][1] = kinv_11_12_r[63:32];
    kin[1][2] = kinv_11_12_r[31:0];
    kin[2][0] = kinv_20_21_r[63:32];
    kin[2][1] = kinv_20_21_r[31:0];
    kin[2][2] = kinv_22_r;
    hin[0][0] = in_h_00;
    hin[0][1] = in_h_01;
    hin[0][2] = in_h_02;
    hin[1][0] = in_h_10;
    hin[1][1] = in_h_11;
    hin[1][2] = in_h_12;
    hin[2][0] = in_h_20;
    hin[2][1] = in_h_21;
    hin[2][2] = in_h_22;
  end

  // ---------------- valid chain ----------------
  logic [FRONT_STG-1:0] fv_r;
  logic [SQRT_STEPS:0]  sqv_r;
  logic                 mv_r;
  logic [DIV_STEPS:0]   dvv_r;
  logic                 fin_v_r;
  logic                 xv_r;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      sqv_r       <= '0;
      mv_r        <= 1'b0;
      dvv_r       <= '0;
      fin_v_r     <= 1'b0;
      xv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fv_r        <= {fv_r[FRONT_STG-2:0], start & ~busy & in_tag_detected};
      sqv_r       <= {sqv_r[SQRT_STEPS-1:0], fv_r[FRONT_STG-1]};
      mv_r        <= sqv_r[SQRT_STEPS];
      dvv_r       <= {dvv_r[DIV_STEPS-1:0], mv_r};
      fin_v_r     <= dvv_r[DIV_STEPS];
      xv_r        <= fin_v_r;
      out_valid_r <= xv_r;
    end
  end

  // ---------------- A = Kinv * H ----------------
  logic signed [63:0] prod_r [27];
  logic signed [61:0] tr_nxt [27];
  logic signed [61:0] tr_r   [27];
  logic signed [62:0] a_nxt  [9];
  logic signed [62:0] a_r    [9];
  logic [61:0]        amag_nxt [9];
  logic [61:0]        amag4_r  [9];
  logic [8:0]         asgn4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int n = 0; n < 3; n++) begin
          prod_r[(i*3+j)*3+n] <= kin[i][n] * hin[n][j];
        end
      end
    end
  end

  // each product truncates toward zero after dropping two bits
  always_comb begin
    logic [63:0] pm;
    for (int p = 0; p < 27; p++) begin
      pm = prod_r[p][63] ? 64'(-prod_r[p]) : prod_r[p];
      tr_nxt[p] = prod_r[p][63] ? -$signed({1'b0, pm[62:2]}) : $signed({1'b0, pm[62:2]});
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      a_nxt[e] = 63'(tr_r[3*e]) + 63'(tr_r[3*e+1]) + 63'(tr_r[3*e+2]);
      amag_nxt[e] = a_r[e][62] ? 62'(-a_r[e]) : 62'(a_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    tr_r <= tr_nxt;
    a_r  <= a_nxt;
    amag4_r <= amag_nxt;
    for (int e = 0; e < 9; e++) begin
      asgn4_r[e] <= a_r[e][62];
    end
  end

  // ---------------- common scale ----------------
  logic [61:0] gmax_nxt [3];
  logic [61:0] gmax_r   [3];
  logic [61:0] amag5_r  [9];
  logic [8:0]  asgn5_r;
  logic [61:0] m_nxt;
  logic [61:0] m_r;
  logic [61:0] amag6_r  [9];
  logic [8:0]  asgn6_r;

  always_comb begin
    logic [61:0] t;
    for (int g = 0; g < 3; g++) begin
      t = (amag4_r[3*g] > amag4_r[3*g+1]) ? amag4_r[3*g] : amag4_r[3*g+1];
      gmax_nxt[g] = (t > amag4_r[3*g+2]) ? t : amag4_r[3*g+2];
    end
    t     = (gmax_r[0] > gmax_r[1]) ? gmax_r[0] : gmax_r[1];
    m_nxt = (t > gmax_r[2]) ? t : gmax_r[2];
  end

  always_ff @(posedge clk) begin
    gmax_r  <= gmax_nxt;
    amag5_r <= amag4_r;
    asgn5_r <= asgn4_r;
    m_r     <= m_nxt;
    amag6_r <= amag5_r;
    asgn6_r <= asgn5_r;
  end

  logic [5:0]  blen;
  logic        sh_right_nxt, sh_right_r;
  logic [4:0]  sh_amt_nxt, sh_amt_r;
  logic [61:0] amag7_r [9];
  logic [8:0]  asgn7_r;

  // bit length of the largest magnitude picks the shift direction and amount
  always_comb begin
    blen = '0;
    for (int i = 0; i < 62; i++) begin
      if (m_r[i]) blen = 6'(i + 1);
    end
    sh_right_nxt = (blen >= 6'd32);
    sh_amt_nxt   = sh_right_nxt ? 5'(blen - 6'd31) : 5'(6'd31 - blen);
  end

  always_ff @(posedge clk) begin
    sh_right_r <= sh_right_nxt;
    sh_amt_r   <= sh_amt_nxt;
    amag7_r    <= amag6_r;
    asgn7_r    <= asgn6_r;
  end

  word_t              b_nxt [9];
  word_t              b8_r  [9];
  word_t              b9_r  [9];
  logic signed [63:0] sqw   [6];
  logic [61:0]        sqa_r [3];
  logic [61:0]        sqb_r [3];

  always_comb begin
    logic [30:0] bm;
    for (int e = 0; e < 9; e++) begin
      bm = sh_right_r ? 31'(amag7_r[e] >> sh_amt_r) : 31'(amag7_r[e] << sh_amt_r);
      b_nxt[e] = asgn7_r[e] ? -$signed({1'b0, bm}) : $signed({1'b0, bm});
    end
    for (int i = 0; i < 3; i++) begin
      sqw[i]   = b8_r[3*i] * b8_r[3*i];
      sqw[3+i] = b8_r[3*i+1] * b8_r[3*i+1];
    end
  end

  always_ff @(posedge clk) begin
    b8_r <= b_nxt;
    b9_r <= b8_r;
    for (int i = 0; i < 3; i++) begin
      sqa_r[i] <= sqw[i][61:0];
      sqb_r[i] <= sqw[3+i][61:0];
    end
  end

  // ---------------- column norms ----------------
  sq_t sq_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      sq_r[0].b[e] <= b9_r[e];
    end
    sq_r[0].la.x    <= 64'(sqa_r[0]) + 64'(sqa_r[1]) + 64'(sqa_r[2]);
    sq_r[0].la.rem  <= '0;
    sq_r[0].la.root <= '0;
    sq_r[0].lb.x    <= 64'(sqb_r[0]) + 64'(sqb_r[1]) + 64'(sqb_r[2]);
    sq_r[0].lb.rem  <= '0;
    sq_r[0].lb.root <= '0;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sq_r[j+1].b  <= sq_r[j].b;
      sq_r[j+1].la <= sqrt_step(sq_r[j].la);
      sq_r[j+1].lb <= sqrt_step(sq_r[j].lb);
    end
  end

  // ---------------- translation scale ----------------
  mt_t         mt_r;
  logic [32:0] nsum;
  logic [42:0] den_nxt;
  logic [42:0] num_nxt [3];

  always_comb begin
    word_t       bv;
    logic [30:0] bm;
    nsum    = 33'(sq_r[SQRT_STEPS].la.root) + 33'(sq_r[SQRT_STEPS].lb.root);
    den_nxt = nsum * MM_PER_M;
    for (int i = 0; i < 3; i++) begin
      bv = sq_r[SQRT_STEPS].b[3*i+2];
      bm = bv[31] ? 31'(-bv) : bv[30:0];
      num_nxt[i] = bm * tag_side_r;
    end
  end

  always_ff @(posedge clk) begin
    mt_r.b   <= sq_r[SQRT_STEPS].b;
    mt_r.na  <= sq_r[SQRT_STEPS].la.root;
    mt_r.nb  <= sq_r[SQRT_STEPS].lb.root;
    mt_r.den <= den_nxt;
    for (int i = 0; i < 3; i++) begin
      mt_r.num[i] <= num_nxt[i];
    end
  end

  // ---------------- dividers ----------------
  dv_t   dv_nxt;
  dv_t   dv_r [DIV_STEPS+1];

  always_comb begin
    word_t       bv;
    logic [30:0] bm;
    rdiv_t       rd;
    tdiv_t       td;
    dv_nxt.na    = mt_r.na;
    dv_nxt.nb    = mt_r.nb;
    dv_nxt.den   = mt_r.den;
    dv_nxt.na_z  = (mt_r.na == '0);
    dv_nxt.nb_z  = (mt_r.nb == '0);
    dv_nxt.den_z = (mt_r.den == '0);
    for (int l = 0; l < 6; l++) begin
      bv = (l < 3) ? mt_r.b[3*l] : mt_r.b[3*(l-3)+1];
      bm = bv[31] ? 31'(-bv) : bv[30:0];
      dv_nxt.rsgn[l] = bv[31];
      rd.rem = 32'(bm >> 2);
      rd.q   = '0;
      rd.lo  = {bm[1:0], 30'd0};
      dv_nxt.rot[l] = rd;
    end
    for (int i = 0; i < 3; i++) begin
      bv = mt_r.b[3*i+2];
      dv_nxt.tsgn[i] = bv[31];
      // quotient would reach 2^32: translation saturates
      dv_nxt.tsat[i] = ((mt_r.num[i] >> 8) >= mt_r.den);
      td.rem = mt_r.num[i] >> 8;
      td.q   = '0;
      td.lo  = {mt_r.num[i][7:0], 24'd0};
      dv_nxt.tr[i] = td;
    end
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= dv_nxt;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_r[j+1].rsgn  <= dv_r[j].rsgn;
      dv_r[j+1].tsgn  <= dv_r[j].tsgn;
      dv_r[j+1].tsat  <= dv_r[j].tsat;
      dv_r[j+1].na_z  <= dv_r[j].na_z;
      dv_r[j+1].nb_z  <= dv_r[j].nb_z;
      dv_r[j+1].den_z <= dv_r[j].den_z;
      dv_r[j+1].na    <= dv_r[j].na;
      dv_r[j+1].nb    <= dv_r[j].nb;
      dv_r[j+1].den   <= dv_r[j].den;
      for (int l = 0; l < 6; l++) begin
        dv_r[j+1].rot[l] <= rdiv_step(dv_r[j].rot[l], (l < 3) ? dv_r[j].na : dv_r[j].nb);
      end
      for (int i = 0; i < 3; i++) begin
        dv_r[j+1].tr[i] <= tdiv_step(dv_r[j].tr[i], dv_r[j].den);
      end
    end
  end

  // ---------------- sign, zero norm and saturation ----------------
  word_t rf_nxt [6];
  word_t rf_r   [6];
  word_t tf_nxt [3];
  word_t tf_r   [3];

  always_comb begin
    rdiv_t       rd;
    tdiv_t       td;
    logic        zn;
    logic [31:0] q;
    for (int l = 0; l < 6; l++) begin
      rd = dv_r[DIV_STEPS].rot[l];
      zn = (l < 3) ? dv_r[DIV_STEPS].na_z : dv_r[DIV_STEPS].nb_z;
      if (zn) rf_nxt[l] = '0;
      else if (dv_r[DIV_STEPS].rsgn[l]) rf_nxt[l] = -rd.q;
      else rf_nxt[l] = rd.q;
    end
    for (int i = 0; i < 3; i++) begin
      td = dv_r[DIV_STEPS].tr[i];
      q  = td.q;
      if (dv_r[DIV_STEPS].den_z) begin
        tf_nxt[i] = '0;
      end else if (dv_r[DIV_STEPS].tsat[i]) begin
        tf_nxt[i] = dv_r[DIV_STEPS].tsgn[i] ? WORD_MIN : WORD_MAX;
      end else if (dv_r[DIV_STEPS].tsgn[i]) begin
        tf_nxt[i] = (q > WORD_MIN) ? WORD_MIN : -q;
      end else begin
        tf_nxt[i] = (q > WORD_MAX) ? WORD_MAX : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    rf_r <= rf_nxt;
    tf_r <= tf_nxt;
  end

  // ---------------- r3 = r1 x r2 ----------------
  // rf_r[0..2] is column 0 (rows 0..2), rf_r[3..5] is column 1
  logic signed [63:0] xp_nxt [6];
  logic signed [63:0] xp_r   [6];
  word_t              rx_r   [6];
  word_t              tx_r   [3];

  always_comb begin
    xp_nxt[0] = rf_r[1] * rf_r[5];
    xp_nxt[1] = rf_r[2] * rf_r[4];
    xp_nxt[2] = rf_r[2] * rf_r[3];
    xp_nxt[3] = rf_r[0] * rf_r[5];
    xp_nxt[4] = rf_r[0] * rf_r[4];
    xp_nxt[5] = rf_r[1] * rf_r[3];
  end

  always_ff @(posedge clk) begin
    xp_r <= xp_nxt;
    rx_r <= rf_r;
    tx_r <= tf_r;
  end

  word_t r3_nxt [3];

  always_comb begin
    logic signed [63:0] d;
    logic [63:0]        dm;
    logic [33:0]        sm;
    for (int k = 0; k < 3; k++) begin
      d  = xp_r[2*k] - xp_r[2*k+1];
      dm = d[63] ? 64'(-d) : d;
      sm = dm[63:30];
      if (d[63]) r3_nxt[k] = (sm > 34'(WORD_MIN)) ? WORD_MIN : 32'(-sm);
      else       r3_nxt[k] = (sm > 34'(WORD_MAX)) ? WORD_MAX : sm[31:0];
    end
  end

  logic [31:0] r_out_r [9];
  logic [31:0] t_out_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r_out_r[3*i]   <= rx_r[i];
      r_out_r[3*i+1] <= rx_r[3+i];
      r_out_r[3*i+2] <= r3_nxt[i];
      t_out_r[i]     <= tx_r[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_r_00  = r_out_r[0];
  assign out_r_01  = r_out_r[1];
  assign out_r_02  = r_out_r[2];
  assign out_r_10  = r_out_r[3];
  assign out_r_11  = r_out_r[4];
  assign out_r_12  = r_out_r[5];
  assign out_r_20  = r_out_r[6];
  assign out_r_21  = r_out_r[7];
  assign out_r_22  = r_out_r[8];
  assign out_t_x   = t_out_r[0];
  assign out_t_y   = t_out_r[1];
  assign out_t_z   = t_out_r[2];

endmodule
